// File: hdl/aging_priority_ready_queue_unit_macros.svh
// Assertion macros for the ready queue unit.
`ifndef AGING_PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define AGING_PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
// Implication that must hold on every clock edge outside reset.
`define APRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after its antecedent.
`define APRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/aprq_pkg.sv
// ----------------------------------------------------------------------------
// aprq_pkg
// Types, codes and constants for the aging priority ready queue.
// ----------------------------------------------------------------------------
`default_nettype none
package aprq_pkg;
  localparam int unsigned QueueDepthDefault = 64;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SORT = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] proc_id;
    logic [7:0] priority_req;
    logic       still_running;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_id;
    logic [7:0] out_priority;
    logic [1:0] status;
    logic [6:0] entries;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [5:0] id;
    logic [7:0] prio;
    logic [7:0] wait_cnt;
  } entry_t;
endpackage
`default_nettype wire

// File: hdl/aprq_mem.sv
// ----------------------------------------------------------------------------
// aprq_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module aprq_mem
  import aprq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);
  entry_t mem [QUEUE_DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/aging_priority_ready_queue_unit.sv
// One command is handled at a time. Dequeue, tick and sort step entry by entry through
// the one-read, one-write entry store. Busy is high from the command transfer to the
// result strobe, so the next command is taken only after the strobe. The receiver
// cannot hold results off.
// Reset (synchronous) empties the queue and clears the aging threshold; the entry store
// itself is not cleared.
`default_nettype none
`include "aging_priority_ready_queue_unit_macros.svh"
module aging_priority_ready_queue_unit
  import aprq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire in_item_t in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  wire logic  cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_WAIT = 7'b0000100,
    S_PROC = 7'b0001000,
    S_SRDJ = 7'b0010000,
    S_SCMP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [7:0]      thr_r;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [CW-1:0]   i_r, i_nxt, j_r, j_nxt;
  entry_t          held_r, held_nxt;
  logic [5:0]      oid_r, oid_nxt;
  logic [7:0]      oprio_r, oprio_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata, aged;
  logic [7:0]      winc;
  logic            wb_pend_r;
  logic [AW-1:0]   wb_addr_r;
  entry_t          wb_data_r;

  aprq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Aged copy of the entry just read.
  always_comb begin
    aged = rdata;
    winc = (rdata.wait_cnt == 8'hff) ? rdata.wait_cnt : rdata.wait_cnt + 8'd1;
    aged.wait_cnt = winc;
    if (winc == thr_r) begin
      aged.wait_cnt = 8'd0;
      if (rdata.prio != 8'hff) aged.prio = rdata.prio + 8'd1;
    end
  end

  // Command sequencer. Sort keeps entry i in held_r and scans j upward,
  // writing a swap into slot j at once; slot i is written after the scan.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    held_nxt  = held_r;
    oid_nxt   = oid_r;
    oprio_nxt = oprio_r;
    stat_nxt  = stat_r;
    we        = 1'b0;
    waddr     = i_r[AW-1:0];
    wdata     = rdata;
    raddr     = i_r[AW-1:0];
    // The delayed sort write-back only falls in a read or done cycle.
    if (wb_pend_r) begin
      we    = 1'b1;
      waddr = wb_addr_r;
      wdata = wb_data_r;
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_item.cmd;
          oid_nxt   = '0;
          oprio_nxt = '0;
          stat_nxt  = ST_OK;
          i_nxt     = '0;
          state_nxt = S_DONE;
          unique case (cmd_t'(in_item.cmd))
            CMD_ENQ: begin
              if (!in_item.still_running) begin
                stat_nxt = ST_FINISHED;
              end else if (count_r == CW'(QUEUE_DEPTH)) begin
                stat_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = '{id: in_item.proc_id, prio: in_item.priority_req,
                              wait_cnt: 8'd0};
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_DEQ: begin
              if (count_r == '0) stat_nxt = ST_EMPTY;
              else state_nxt = S_RD;
            end
            default: begin
              if (count_r != '0) state_nxt = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        raddr = i_r[AW-1:0];
        state_nxt = S_PROC;
      end
      S_PROC: begin
        unique case (cmd_t'(cmd_r))
          CMD_DEQ: begin
            if (i_r == '0) begin
              oid_nxt   = rdata.id;
              oprio_nxt = rdata.prio;
            end else begin
              we    = 1'b1;
              waddr = AW'(i_r - CW'(1));
              wdata = rdata;
            end
            i_nxt = i_r + CW'(1);
            if (i_r + CW'(1) == count_r) begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RD;
            end
          end
          CMD_TICK: begin
            we    = 1'b1;
            wdata = aged;
            i_nxt = i_r + CW'(1);
            state_nxt = (i_r + CW'(1) == count_r) ? S_DONE : S_RD;
          end
          default: begin
            // Sort: latch entry i, begin scan at i+1.
            held_nxt = rdata;
            j_nxt    = i_r + CW'(1);
            state_nxt = (i_r + CW'(1) >= count_r) ? S_DONE : S_SRDJ;
          end
        endcase
      end
      S_SRDJ: begin
        raddr = j_r[AW-1:0];
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_SCMP;
        raddr = j_r[AW-1:0];
      end
      S_SCMP: begin
        if (held_r.prio < rdata.prio) begin
          we       = 1'b1;
          waddr    = j_r[AW-1:0];
          wdata    = held_r;
          held_nxt = rdata;
        end
        j_nxt = j_r + CW'(1);
        if (j_r + CW'(1) == count_r) begin
          state_nxt = S_DONE;
          if (held_r.prio < rdata.prio) begin
            // Entry i takes the final held value below.
          end
        end else begin
          state_nxt = S_SRDJ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sort write-back of the held entry into slot i, then advance to the next i.
  logic sort_wb;
  assign sort_wb = (state_r == S_SCMP) && (j_r + CW'(1) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      thr_r   <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      count_r <= count_nxt;
      if (sort_wb && (i_r + CW'(2) < count_r)) state_r <= S_RD;
      else state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    j_r     <= j_nxt;
    held_r  <= held_nxt;
    oid_r   <= oid_nxt;
    oprio_r <= oprio_nxt;
    stat_r  <= stat_nxt;
    i_r     <= sort_wb ? i_r + CW'(1) : i_nxt;
  end

  // Second write port use is avoided: slot i is written through a registered write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) wb_pend_r <= 1'b0;
    else wb_pend_r <= sort_wb;
    wb_addr_r <= i_r[AW-1:0];
    wb_data_r <= (held_r.prio < rdata.prio) ? rdata : held_r;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_item  = '{out_id: oid_r, out_priority: oprio_r, status: stat_r,
                       entries: 7'(count_r)};

  `APRQ_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(QUEUE_DEPTH), "count overflow")
  `APRQ_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
  `APRQ_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, busy, "strobe while idle")
endmodule
`default_nettype wire

// File: sim/tb_aging_priority_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the aging priority ready queue
// Drives enqueue, dequeue, sort and aging-tick commands through the start and
// busy handshake in random bursts. A shadow ready queue predicts every result
// transfer, and each strobed result is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_aging_priority_ready_queue_unit;
  import aprq_pkg::*;

  localparam int unsigned Depth      = QueueDepthDefault;
  localparam int unsigned CycleLimit = 30_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    in_item   = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // Commands waiting to be sent and results still owed by the block.
  in_item_t    cmd_backlog[$];
  out_item_t   owed_results[$];

  // Shadow copy of the ready queue and the aging threshold.
  logic [5:0]  shadow_id[Depth];
  logic [7:0]  shadow_prio[Depth];
  logic [7:0]  shadow_wait[Depth];
  int unsigned shadow_count;
  logic [7:0]  shadow_threshold;

  logic        took;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned status_seen[4];

  aging_priority_ready_queue_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow queue and return the result it causes.
  function automatic out_item_t apply_queue_command(in_item_t c);
    out_item_t  r;
    logic [5:0] tid;
    logic [7:0] tpr;
    logic [7:0] twt;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_ENQ: begin
        if (!c.still_running) begin
          r.status = ST_FINISHED;
        end else if (shadow_count >= Depth) begin
          r.status = ST_FULL;
        end else begin
          shadow_id[shadow_count]   = c.proc_id;
          shadow_prio[shadow_count] = c.priority_req;
          shadow_wait[shadow_count] = '0;
          shadow_count++;
        end
      end
      CMD_DEQ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_id       = shadow_id[0];
          r.out_priority = shadow_prio[0];
          for (int i = 0; i + 1 < shadow_count; i++) begin
            shadow_id[i]   = shadow_id[i+1];
            shadow_prio[i] = shadow_prio[i+1];
            shadow_wait[i] = shadow_wait[i+1];
          end
          shadow_count--;
        end
      end
      CMD_SORT: begin
        // Exchange sort, highest priority first; equal priorities are not swapped.
        for (int i = 0; i < shadow_count; i++) begin
          for (int j = i + 1; j < shadow_count; j++) begin
            if (shadow_prio[i] < shadow_prio[j]) begin
              tid = shadow_id[i];   shadow_id[i]   = shadow_id[j];   shadow_id[j]   = tid;
              tpr = shadow_prio[i]; shadow_prio[i] = shadow_prio[j]; shadow_prio[j] = tpr;
              twt = shadow_wait[i]; shadow_wait[i] = shadow_wait[j]; shadow_wait[j] = twt;
            end
          end
        end
      end
      default: begin
        // Aging tick: the wait saturates, and reaching the threshold promotes.
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_wait[i] != 8'hFF) shadow_wait[i]++;
          if (shadow_wait[i] == shadow_threshold) begin
            if (shadow_prio[i] != 8'hFF) shadow_prio[i]++;
            shadow_wait[i] = '0;
          end
        end
      end
    endcase
    r.entries = 7'(shadow_count);
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] c, logic [5:0] id, logic [7:0] pr,
                                        logic run);
    in_item_t m;
    m.cmd           = c;
    m.proc_id       = id;
    m.priority_req  = pr;
    m.still_running = run;
    return m;
  endfunction

  // Random command; enq_pct and deq_pct steer the fill level of the queue.
  function automatic in_item_t random_cmd(int unsigned enq_pct, int unsigned deq_pct);
    int unsigned roll;
    logic [1:0]  c;
    roll = $urandom_range(99);
    if (roll < enq_pct) c = CMD_ENQ;
    else if (roll < enq_pct + deq_pct) c = CMD_DEQ;
    else if ($urandom_range(3) == 0) c = CMD_SORT;
    else c = CMD_TICK;
    return make_cmd(c, 6'($urandom), 8'($urandom), $urandom_range(9) != 0);
  endfunction

  // Driver: the sender works in bursts with random gaps between them.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // The current command has not been taken yet, so it is held.
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (cmd_backlog.size() != 0) begin
      in_item <= cmd_backlog.pop_front();
      start   <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(40, 1);
        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: record command transfers and check every result transfer.
  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      owed_results.push_back(apply_queue_command(in_item));
    end
    if (rst_n && out_valid) begin
      checked_count <= checked_count + 1;
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_item);
        error_count = error_count + 1;
      end else begin
        want = owed_results.pop_front();
        status_seen[want.status] <= status_seen[want.status] + 1;
        if (out_item.out_id !== want.out_id) begin
          $error("out_id: expected %0d, got %0d", want.out_id, out_item.out_id);
          error_count = error_count + 1;
        end
        if (out_item.out_priority !== want.out_priority) begin
          $error("out_priority: expected %0d, got %0d", want.out_priority,
                 out_item.out_priority);
          error_count = error_count + 1;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          error_count = error_count + 1;
        end
        if (out_item.entries !== want.entries) begin
          $error("entries: expected %0d, got %0d", want.entries, out_item.entries);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait until the block has drained every command and returned every result.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || owed_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    shadow_threshold = value;
  endtask

  initial begin
    logic [7:0] thresholds[6];
    burst_left       = 1;
    gap_left         = 0;
    took             = 1'b0;
    cycle_count      = 0;
    error_count      = 0;
    checked_count    = 0;
    shadow_count     = 0;
    shadow_threshold = '0;
    foreach (status_seen[k]) status_seen[k] = 0;
    thresholds = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3, 8'($urandom_range(2, 254))};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (thresholds[ph]) begin
      write_threshold(thresholds[ph]);
      if (ph == 0) begin
        // Directed: empty queue cases, field extremes, ties and every command.
        cmd_backlog.push_back(make_cmd(CMD_ENQ, 6'd63, 8'd255, 1'b0));
        cmd_backlog.push_back(make_cmd(CMD_DEQ, 6'd0, 8'd0, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_SORT, 6'd0, 8'd0, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_TICK, 6'd0, 8'd0, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_ENQ, 6'd0, 8'd0, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_ENQ, 6'd63, 8'd255, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_ENQ, 6'd21, 8'd128, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_ENQ, 6'd42, 8'd255, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_ENQ, 6'd5, 8'd0, 1'b0));
        cmd_backlog.push_back(make_cmd(CMD_TICK, 6'd0, 8'd0, 1'b1));
        cmd_backlog.push_back(make_cmd(CMD_SORT, 6'd0, 8'd0, 1'b1));
        for (int i = 0; i < 5; i++) begin
          cmd_backlog.push_back(make_cmd(CMD_DEQ, 6'd63, 8'd255, 1'b0));
        end
      end else begin
        // Fill until the queue overflows, then mix and drain.
        for (int i = 0; i < 85; i++) cmd_backlog.push_back(random_cmd(90, 3));
        for (int i = 0; i < 10; i++) cmd_backlog.push_back(random_cmd(25, 40));
      end
      if (ph == 4) begin
        // A run of ticks promotes every queued entry many times over.
        for (int i = 0; i < 40; i++) begin
          cmd_backlog.push_back(make_cmd(CMD_TICK, 6'($urandom), 8'($urandom), 1'b1));
        end
      end
      // Hold off sending until every expected result has come back.
      wait_drained();
      if (ph == 2) begin
        write_threshold(8'd255);
        for (int i = 0; i < 260; i++) begin
          cmd_backlog.push_back(make_cmd(CMD_TICK, 6'd0, 8'd0, 1'b1));
        end
        cmd_backlog.push_back(make_cmd(CMD_SORT, 6'd0, 8'd0, 1'b1));
        wait_drained();
      end
    end
    repeat (20) @(negedge clk);

    $display("Checked %0d results under six aging thresholds.", checked_count);
    $display("Status counts: ok %0d, empty %0d, full %0d, finished %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_FINISHED]);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
